### src/button_press_pattern_detector_defines.svh
// Assertion macros for the button press pattern detector.
// Included by the RTL files that carry assertions; depends on nothing.
// The macros assume a clock named clk and an active-low reset named rst_n.
`ifndef BUTTON_PRESS_PATTERN_DETECTOR_DEFINES_SVH
`define BUTTON_PRESS_PATTERN_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BPPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BPPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BPPD_ASSERT_IMP(lbl, ante, cons)
`define BPPD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### src/bppd_pkg.sv
// Shared types and constants of the button press pattern detector.
// Used by every module of the block; depends on nothing.
package bppd_pkg;

  localparam int unsigned CNT_W = 8;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] SHORT_TICKS_RST = 8'd2;
  localparam logic [CNT_W-1:0] LONG_TICKS_RST = 8'd60;
  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SAMPLE1 = 3'd1,
    PH_WAIT2   = 3'd2,
    PH_SAMPLE2 = 3'd3,
    PH_WAIT3   = 3'd4,
    PH_SAMPLE3 = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    EV_LONG       = 2'd0,
    EV_SHORT_LONG = 2'd1,
    EV_SHORT2_LONG = 2'd2
  } ev_code_t;

  typedef enum logic {
    REG_SHORT = 1'b0,
    REG_LONG  = 1'b1
  } reg_idx_t;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_EDGE = 1'b1
  } mode_t;

  typedef struct packed {
    logic [CNT_W-1:0] short_ticks;
    logic [CNT_W-1:0] long_ticks;
  } cfg_t;

  typedef struct packed {
    logic mode;
    logic pin_level;
  } item_t;

  typedef struct packed {
    logic       event_valid;
    logic [1:0] event_code;
    logic       sampling_active;
  } result_t;

endpackage

### src/bppd_if.sv
// Valid/ready channel interfaces of the button press pattern detector.
// Depends on nothing; one interface for input beats, one for result beats.
interface bppd_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic pin_level;

  modport source (output valid, output mode, output pin_level, input ready);
  modport sink (input valid, input mode, input pin_level, output ready);
endinterface

interface bppd_out_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic [1:0] event_code;
  logic       sampling_active;

  modport source (output valid, output event_valid, output event_code,
                  output sampling_active, input ready);
  modport sink (input valid, input event_valid, input event_code,
                input sampling_active, output ready);
endinterface

### src/bppd_cfg.sv
// APB-style register file holding the short and long press limits.
// Depends on bppd_pkg.
module bppd_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bppd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [bppd_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [bppd_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output bppd_pkg::cfg_t                    cfg
);

  logic [bppd_pkg::CNT_W-1:0] short_ticks_r;
  logic [bppd_pkg::CNT_W-1:0] long_ticks_r;
  logic                       wr_en;
  bppd_pkg::reg_idx_t         idx;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx = bppd_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_ticks_r <= bppd_pkg::SHORT_TICKS_RST;
      long_ticks_r <= bppd_pkg::LONG_TICKS_RST;
    end else if (wr_en) begin
      unique case (idx)
        bppd_pkg::REG_SHORT: short_ticks_r <= cfg_pwdata[bppd_pkg::CNT_W-1:0];
        bppd_pkg::REG_LONG:  long_ticks_r <= cfg_pwdata[bppd_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      bppd_pkg::REG_SHORT: cfg_prdata[bppd_pkg::CNT_W-1:0] = short_ticks_r;
      bppd_pkg::REG_LONG:  cfg_prdata[bppd_pkg::CNT_W-1:0] = long_ticks_r;
      default: cfg_prdata = '0;
    endcase
  end

  assign cfg.short_ticks = short_ticks_r;
  assign cfg.long_ticks = long_ticks_r;

endmodule

### src/bppd_in_reg.sv
// Input register that captures one beat from the input channel.
// Depends on bppd_pkg and bppd_in_if.
module bppd_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  bppd_in_if.sink         in_ch,
  input  logic            take,
  output logic            item_valid,
  output bppd_pkg::item_t item
);

  logic            valid_r;
  logic            valid_nxt;
  bppd_pkg::item_t item_r;
  logic            load;

  assign in_ch.ready = ~valid_r | take;
  assign load = in_ch.valid & in_ch.ready;
  assign valid_nxt = load | (valid_r & ~take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.mode <= in_ch.mode;
      item_r.pin_level <= in_ch.pin_level;
    end
  end

  assign item_valid = valid_r;
  assign item = item_r;

endmodule

### src/bppd_core.sv
// Press pattern state machine: phase and tick counter, one beat per cycle while take is high.
// Depends on bppd_pkg and the assertion macro header.
`include "button_press_pattern_detector_defines.svh"

module bppd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  bppd_pkg::item_t   item,
  input  bppd_pkg::cfg_t    cfg,
  output bppd_pkg::result_t result
);

  bppd_pkg::phase_t           phase_r;
  bppd_pkg::phase_t           phase_nxt;
  logic [bppd_pkg::CNT_W-1:0] cnt_r;
  logic [bppd_pkg::CNT_W-1:0] cnt_nxt;
  logic [bppd_pkg::CNT_W-1:0] cnt_sat;
  logic                       ev_valid;
  bppd_pkg::ev_code_t         ev_code;
  logic                       released;

  assign released = item.pin_level;
  assign cnt_sat = (cnt_r == bppd_pkg::CNT_MAX) ? cnt_r : cnt_r + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bppd_pkg::PH_IDLE;
      cnt_r <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt = cnt_r;
    ev_valid = 1'b0;
    ev_code = bppd_pkg::EV_LONG;
    if (bppd_pkg::mode_t'(item.mode) == bppd_pkg::MODE_EDGE) begin
      unique case (phase_r)
        bppd_pkg::PH_IDLE, bppd_pkg::PH_SAMPLE1: begin
          phase_nxt = bppd_pkg::PH_SAMPLE1;
          cnt_nxt = '0;
        end
        bppd_pkg::PH_WAIT2: begin
          phase_nxt = bppd_pkg::PH_SAMPLE2;
          cnt_nxt = '0;
        end
        bppd_pkg::PH_WAIT3: begin
          phase_nxt = bppd_pkg::PH_SAMPLE3;
          cnt_nxt = '0;
        end
        default: ;
      endcase
    end else begin
      unique case (phase_r)
        bppd_pkg::PH_SAMPLE1, bppd_pkg::PH_SAMPLE2, bppd_pkg::PH_SAMPLE3: begin
          if (released) begin
            cnt_nxt = '0;
            if (cnt_r >= cfg.short_ticks) begin
              unique case (phase_r)
                bppd_pkg::PH_SAMPLE1: phase_nxt = bppd_pkg::PH_WAIT2;
                bppd_pkg::PH_SAMPLE2: phase_nxt = bppd_pkg::PH_WAIT3;
                default:              phase_nxt = bppd_pkg::PH_IDLE;
              endcase
            end else begin
              phase_nxt = bppd_pkg::PH_IDLE;
            end
          end else if (cnt_sat >= cfg.long_ticks) begin
            phase_nxt = bppd_pkg::PH_IDLE;
            cnt_nxt = '0;
            ev_valid = 1'b1;
            unique case (phase_r)
              bppd_pkg::PH_SAMPLE1: ev_code = bppd_pkg::EV_LONG;
              bppd_pkg::PH_SAMPLE2: ev_code = bppd_pkg::EV_SHORT_LONG;
              default:              ev_code = bppd_pkg::EV_SHORT2_LONG;
            endcase
          end else begin
            cnt_nxt = cnt_sat;
          end
        end
        bppd_pkg::PH_WAIT2, bppd_pkg::PH_WAIT3: begin
          cnt_nxt = released ? cnt_sat : cnt_r;
          if (cnt_nxt >= cfg.long_ticks) begin
            phase_nxt = bppd_pkg::PH_IDLE;
            cnt_nxt = '0;
          end
        end
        default: begin
          phase_nxt = bppd_pkg::PH_IDLE;
          cnt_nxt = '0;
        end
      endcase
    end
  end

  assign result.event_valid = ev_valid;
  assign result.event_code = ev_code;
  assign result.sampling_active = (phase_nxt != bppd_pkg::PH_IDLE);

  // A reported pattern always ends the sequence.
  `BPPD_ASSERT_IMP(a_event_ends_in_idle, ev_valid, phase_nxt == bppd_pkg::PH_IDLE)
  // The code is only nonzero alongside a report.
  `BPPD_ASSERT_IMP(a_code_needs_event, ev_code != bppd_pkg::EV_LONG, ev_valid)
  // A tick while idle leaves the block idle with a cleared counter.
  `BPPD_ASSERT_NXT(a_idle_tick_stays,
    take && !item.mode && phase_r == bppd_pkg::PH_IDLE,
    phase_r == bppd_pkg::PH_IDLE && cnt_r == '0)

endmodule

### src/bppd_out_reg.sv
// Result register that holds one beat until the output channel takes it.
// Depends on bppd_pkg and bppd_out_if.
module bppd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  bppd_pkg::result_t result,
  output logic              take,
  bppd_out_if.source        out_ch
);

  logic              valid_r;
  logic              valid_nxt;
  bppd_pkg::result_t res_r;

  assign take = item_valid & (~valid_r | out_ch.ready);
  assign valid_nxt = take | (valid_r & ~out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= result;
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.event_valid = res_r.event_valid;
  assign out_ch.event_code = res_r.event_code;
  assign out_ch.sampling_active = res_r.sampling_active;

endmodule

### src/button_press_pattern_detector.sv
// Button press pattern detector for an active-low button. Each input beat is
// either a falling edge on the pin or a sampling tick with the pin level, and
// each one yields exactly one result beat that may report a long press, a short
// press then a long press, or two short presses then a long press, together
// with the tick timer enable. A beat passes an input register, combinational
// state machine logic and a result register, and one beat per cycle is
// sustained while the result side keeps taking beats. The press limits sit in
// an APB-style register file at byte addresses 0 and 4; the user must write
// them only while no beat is in flight, and the block itself does not enforce
// this.
// Depends on bppd_pkg, the channel interfaces and all bppd submodules.
module button_press_pattern_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  bppd_in_if.sink                           in_ch,
  bppd_out_if.source                        out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bppd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [bppd_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [bppd_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  bppd_pkg::cfg_t    cfg;
  bppd_pkg::item_t   item;
  bppd_pkg::result_t result;
  logic              item_valid;
  logic              take;

  bppd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bppd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  bppd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  bppd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule
